@@ hw/rtl/vlec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlec_pkg: shared types and constants for the volume extrema counter
// Holds field widths, register indexes, scan step codes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package vlec_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int COUNT_W    = 16;
   localparam int CFG_W      = 6;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_SIZE_X = 2'd0;
   localparam logic [1:0] REG_SIZE_Y = 2'd1;
   localparam logic [1:0] REG_SIZE_Z = 2'd2;

   localparam logic [CFG_W-1:0] SIZE_RESET = 6'd32;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [COUNT_W-1:0]         count_type;
   typedef logic [CFG_W-1:0]           cfg_type;
   typedef logic [2:0]                 step_type;

   // One voxel is visited in seven reads: the center, then the six faces.
   localparam step_type STEP_CENTER = 3'd0;
   localparam step_type STEP_XM     = 3'd1;
   localparam step_type STEP_XP     = 3'd2;
   localparam step_type STEP_YM     = 3'd3;
   localparam step_type STEP_YP     = 3'd4;
   localparam step_type STEP_ZM     = 3'd5;
   localparam step_type STEP_ZP     = 3'd6;

   typedef struct packed {
      logic load_en;
      logic scan_clear;
      logic scan_issue;
      logic result_load;
   } dp_cmd_type;

   typedef struct packed {
      logic load_last;
      logic issue_last;
   } dp_status_type;

endpackage

@@ hw/rtl/vlec_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlec_ifs: valid/ready channels of the volume extrema counter
// The request channel carries one sample, the response channel one result.
// ----------------------------------------------------------------------------
interface vlec_req_if import vlec_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface vlec_rsp_if import vlec_pkg::*; ();
   logic       valid;
   logic       ready;
   count_type  maxima_count;
   count_type  minima_count;
   sample_type volume_max;
   sample_type volume_min;

   modport source (output valid, output maxima_count, output minima_count,
                   output volume_max, output volume_min, input ready);
   modport sink (input valid, input maxima_count, input minima_count,
                 input volume_max, input volume_min, output ready);
endinterface

@@ hw/rtl/volume_local_extrema_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_local_extrema_counter: strict local extrema count over a 3D volume
// Top level with the register port, the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage. The request channel (req_bus) carries one sample per transaction, in
// raster order with x fastest, then y, then z. A volume holds N = sx*sy*sz
// samples, with the sizes taken from the three size registers on the APB port
// (0 is taken as 1, anything above MAX_DIM as MAX_DIM). Any size write restarts
// loading at the first voxel. Loading takes one transaction per cycle.
// After the last sample the block stops accepting requests and scans the
// stored volume: one single-port RAM read per cycle, seven reads per voxel
// (the center and its six faces). Once the last read has updated the
// counters, the result is registered and appears on
// the response channel (rsp_bus); the next volume can start loading in the
// same cycle. The result sits in an output register: while the receiver
// stalls, the next volume still loads, and only the end of its scan waits
// for the register to empty. Reset clears the controller and the load
// position and sets all sizes to 32; the voxel store is not cleared, since
// every entry whose value a scan uses is written in the same pass.
// ----------------------------------------------------------------------------
module volume_local_extrema_counter import vlec_pkg::*; #(
   parameter int MAX_DIM     = 32,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   vlec_req_if.sink              req_bus,
   vlec_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   // Configuration registers. The word index is paddr[3:2]; writes to the
   // unused fourth word are dropped.
   cfg_type    size_x_ff, size_y_ff, size_z_ff;
   logic       cfg_wr;
   logic [1:0] reg_index;
   logic       cfg_restart;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign cfg_wr    = psel && penable && pwrite;

   always_comb begin
      cfg_restart = 1'b0;
      unique case (reg_index) inside
         REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: cfg_restart = cfg_wr;
         default: cfg_restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
      end else if (cfg_wr) begin
         unique case (reg_index)
            REG_SIZE_X: size_x_ff <= pwdata[CFG_W-1:0];
            REG_SIZE_Y: size_y_ff <= pwdata[CFG_W-1:0];
            REG_SIZE_Z: size_z_ff <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_index)
         REG_SIZE_X: prdata = CSR_DATA_W'(size_x_ff);
         REG_SIZE_Y: prdata = CSR_DATA_W'(size_y_ff);
         REG_SIZE_Z: prdata = CSR_DATA_W'(size_z_ff);
         default:    prdata = '0;
      endcase
   end

   // Clamp a size register to the range 1..MAX_DIM.
   function automatic logic [DIM_W-1:0] clamp_size(input cfg_type v);
      logic [CFG_W:0] wide;
      wide = {1'b0, v};
      if (v == '0) begin
         return DIM_W'(1);
      end else if (wide > (CFG_W + 1)'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end
      return DIM_W'(v);
   endfunction

   logic [DIM_W-1:0] dim_x, dim_y, dim_z;
   assign dim_x = clamp_size(size_x_ff);
   assign dim_y = clamp_size(size_y_ff);
   assign dim_z = clamp_size(size_z_ff);

   dp_cmd_type    cmd;
   dp_status_type status;

   vlec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   vlec_dp #(
      .MAX_DIM     (MAX_DIM),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg_restart  (cfg_restart),
      .dim_x        (dim_x),
      .dim_y        (dim_y),
      .dim_z        (dim_z),
      .req_sample   (req_bus.sample),
      .cmd          (cmd),
      .status       (status),
      .maxima_count (rsp_bus.maxima_count),
      .minima_count (rsp_bus.minima_count),
      .volume_max   (rsp_bus.volume_max),
      .volume_min   (rsp_bus.volume_min)
   );

endmodule

@@ hw/rtl/vlec_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlec_ram: generic single-port RAM
// One address per cycle, write when enabled, read data registered.
// ----------------------------------------------------------------------------
module vlec_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/vlec_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlec_ctrl: sequencing of load, scan and result hand-off
// Drives the datapath commands and owns both channel handshakes.
// ----------------------------------------------------------------------------
module vlec_ctrl import vlec_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_en = 1'b1;
               if (status.load_last) begin
                  cmd.scan_clear = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last read returns and updates the counters here.
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/vlec_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlec_dp: voxel store, address generation, comparison and counters
// Writes samples in raster order, then reads each voxel and its six faces.
// ----------------------------------------------------------------------------
module vlec_dp import vlec_pkg::*; #(
   parameter int MAX_DIM     = 32,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cfg_restart,
   input  logic [$clog2(MAX_DIM+1)-1:0]   dim_x,
   input  logic [$clog2(MAX_DIM+1)-1:0]   dim_y,
   input  logic [$clog2(MAX_DIM+1)-1:0]   dim_z,
   input  sample_type                     req_sample,
   input  dp_cmd_type                     cmd,
   output dp_status_type                  status,
   output count_type                      maxima_count,
   output count_type                      minima_count,
   output sample_type                     volume_max,
   output sample_type                     volume_min
);

   localparam int COORD_W = $clog2(MAX_DIM);
   localparam int ADDR_W  = 3 * COORD_W;
   localparam int DEPTH   = 1 << ADDR_W;

   typedef logic [COORD_W-1:0]             coord_type;
   typedef logic signed [SAMPLE_BITS-1:0]  voxel_type;

   coord_type last_x, last_y, last_z;
   assign last_x = dim_x[COORD_W-1:0] - COORD_W'(1);
   assign last_y = dim_y[COORD_W-1:0] - COORD_W'(1);
   assign last_z = dim_z[COORD_W-1:0] - COORD_W'(1);

   // Load position.
   coord_type lx_ff, ly_ff, lz_ff, lx_in, ly_in, lz_in;
   logic      load_first;
   voxel_type load_value;
   voxel_type run_max_ff, run_min_ff, run_max_in, run_min_in;

   assign load_value = req_sample[SAMPLE_BITS-1:0];
   assign load_first = (lx_ff == '0) && (ly_ff == '0) && (lz_ff == '0);

   always_comb begin
      lx_in      = lx_ff;
      ly_in      = ly_ff;
      lz_in      = lz_ff;
      run_max_in = run_max_ff;
      run_min_in = run_min_ff;
      if (cfg_restart) begin
         lx_in = '0;
         ly_in = '0;
         lz_in = '0;
      end else if (cmd.load_en) begin
         if (load_first || (load_value > run_max_ff)) begin
            run_max_in = load_value;
         end
         if (load_first || (load_value < run_min_ff)) begin
            run_min_in = load_value;
         end
         if (lx_ff != last_x) begin
            lx_in = lx_ff + COORD_W'(1);
         end else begin
            lx_in = '0;
            if (ly_ff != last_y) begin
               ly_in = ly_ff + COORD_W'(1);
            end else begin
               ly_in = '0;
               lz_in = (lz_ff != last_z) ? lz_ff + COORD_W'(1) : '0;
            end
         end
      end
   end

   // Scan position and read step.
   coord_type sx_ff, sy_ff, sz_ff, sx_in, sy_in, sz_in;
   step_type  step_ff, step_in;
   logic      scan_at_last;

   assign scan_at_last = (sx_ff == last_x) && (sy_ff == last_y) && (sz_ff == last_z);

   always_comb begin
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      sz_in   = sz_ff;
      step_in = step_ff;
      if (cmd.scan_clear) begin
         sx_in   = '0;
         sy_in   = '0;
         sz_in   = '0;
         step_in = STEP_CENTER;
      end else if (cmd.scan_issue) begin
         if (step_ff != STEP_ZP) begin
            step_in = step_ff + 3'd1;
         end else begin
            step_in = STEP_CENTER;
            if (sx_ff != last_x) begin
               sx_in = sx_ff + COORD_W'(1);
            end else begin
               sx_in = '0;
               if (sy_ff != last_y) begin
                  sy_in = sy_ff + COORD_W'(1);
               end else begin
                  sy_in = '0;
                  sz_in = (sz_ff != last_z) ? sz_ff + COORD_W'(1) : '0;
               end
            end
         end
      end
   end

   assign status.load_last  = (lx_ff == last_x) && (ly_ff == last_y) && (lz_ff == last_z);
   assign status.issue_last = scan_at_last && (step_ff == STEP_ZP);

   // Neighbor address for the current step; a face outside the grid is not present.
   coord_type ax, ay, az;
   logic      present;

   always_comb begin
      ax      = sx_ff;
      ay      = sy_ff;
      az      = sz_ff;
      present = 1'b1;
      unique case (step_ff)
         STEP_XM: begin
            present = (sx_ff != '0);
            ax      = sx_ff - COORD_W'(1);
         end
         STEP_XP: begin
            present = (sx_ff != last_x);
            ax      = sx_ff + COORD_W'(1);
         end
         STEP_YM: begin
            present = (sy_ff != '0);
            ay      = sy_ff - COORD_W'(1);
         end
         STEP_YP: begin
            present = (sy_ff != last_y);
            ay      = sy_ff + COORD_W'(1);
         end
         STEP_ZM: begin
            present = (sz_ff != '0);
            az      = sz_ff - COORD_W'(1);
         end
         STEP_ZP: begin
            present = (sz_ff != last_z);
            az      = sz_ff + COORD_W'(1);
         end
         default: begin
            present = 1'b1;
         end
      endcase
   end

   // Voxel store, addressed by packed coordinates.
   logic [ADDR_W-1:0]      ram_addr;
   logic [SAMPLE_BITS-1:0] ram_rd_data;
   voxel_type              voxel_rd;

   assign ram_addr = cmd.load_en ? {lz_ff, ly_ff, lx_ff} : {az, ay, ax};
   assign voxel_rd = ram_rd_data;

   vlec_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load_en),
      .addr    (ram_addr),
      .wr_data (load_value),
      .rd_data (ram_rd_data)
   );

   // Read tags are registered like the read data, so both arrive together.
   logic      rd_valid_ff, rd_present_ff;
   step_type  rd_step_ff;
   voxel_type center_ff, center_in;
   logic      is_max_ff, is_min_ff, is_max_in, is_min_in;
   count_type max_cnt_ff, min_cnt_ff, max_cnt_in, min_cnt_in;
   logic      max_next, min_next;

   always_comb begin
      max_next   = is_max_ff & ~(rd_present_ff && (voxel_rd >= center_ff));
      min_next   = is_min_ff & ~(rd_present_ff && (voxel_rd <= center_ff));
      center_in  = center_ff;
      is_max_in  = is_max_ff;
      is_min_in  = is_min_ff;
      max_cnt_in = max_cnt_ff;
      min_cnt_in = min_cnt_ff;
      if (cmd.scan_clear) begin
         max_cnt_in = '0;
         min_cnt_in = '0;
      end else if (rd_valid_ff) begin
         if (rd_step_ff == STEP_CENTER) begin
            center_in = voxel_rd;
            is_max_in = 1'b1;
            is_min_in = 1'b1;
         end else begin
            is_max_in = max_next;
            is_min_in = min_next;
            if (rd_step_ff == STEP_ZP) begin
               max_cnt_in = max_cnt_ff + COUNT_W'(max_next);
               min_cnt_in = min_cnt_ff + COUNT_W'(min_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lx_ff       <= '0;
         ly_ff       <= '0;
         lz_ff       <= '0;
         sx_ff       <= '0;
         sy_ff       <= '0;
         sz_ff       <= '0;
         step_ff     <= STEP_CENTER;
         rd_valid_ff <= 1'b0;
         max_cnt_ff  <= '0;
         min_cnt_ff  <= '0;
      end else begin
         lx_ff       <= lx_in;
         ly_ff       <= ly_in;
         lz_ff       <= lz_in;
         sx_ff       <= sx_in;
         sy_ff       <= sy_in;
         sz_ff       <= sz_in;
         step_ff     <= step_in;
         rd_valid_ff <= cmd.scan_issue;
         max_cnt_ff  <= max_cnt_in;
         min_cnt_ff  <= min_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_step_ff    <= step_ff;
      rd_present_ff <= present;
      center_ff     <= center_in;
      is_max_ff     <= is_max_in;
      is_min_ff     <= is_min_in;
      run_max_ff    <= run_max_in;
      run_min_ff    <= run_min_in;
   end

   // Result register, held until the response is taken.
   count_type  res_max_cnt_ff, res_min_cnt_ff;
   sample_type res_max_ff, res_min_ff;

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         res_max_cnt_ff <= max_cnt_ff;
         res_min_cnt_ff <= min_cnt_ff;
         res_max_ff     <= SAMPLE_W'(run_max_ff);
         res_min_ff     <= SAMPLE_W'(run_min_ff);
      end
   end

   assign maxima_count = res_max_cnt_ff;
   assign minima_count = res_min_cnt_ff;
   assign volume_max   = res_max_ff;
   assign volume_min   = res_min_ff;

endmodule

@@ hw/rtl/vlec_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlec_checker: port-level checks for the volume extrema counter
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module vlec_checker import vlec_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input count_type  maxima_count,
   input count_type  minima_count,
   input sample_type volume_max,
   input sample_type volume_min
);

   // No result is pending right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A held response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(maxima_count)
         && $stable(minima_count) && $stable(volume_max) && $stable(volume_min))
      else $error("response dropped or changed while stalled");

   // A result follows a scan, never the sample accepted just before.
   a_scan_gap: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result appeared right after a sample");

   // The volume range is ordered.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> volume_max >= volume_min)
      else $error("volume maximum below volume minimum");

endmodule

bind volume_local_extrema_counter vlec_checker u_vlec_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .maxima_count (rsp_bus.maxima_count),
   .minima_count (rsp_bus.minima_count),
   .volume_max   (rsp_bus.volume_max),
   .volume_min   (rsp_bus.volume_min)
);
